### src/hlbc_pkg.sv
// Shared constants, codes and control types of the hashed LRU buffer cache.
package hlbc_pkg;

	localparam int NumBuffers = 32;
	localparam int NumBuckets = 13;
	localparam int NodeCount  = NumBuffers + NumBuckets;
	localparam int NodeW      = $clog2(NodeCount);
	localparam int BufIdxW    = $clog2(NumBuffers);
	localparam int BktW       = $clog2(NumBuckets);
	localparam int CntW       = $clog2(NumBuffers + 1);

	localparam int CmdW    = 2;
	localparam int DevW    = 8;
	localparam int BlkW    = 16;
	localparam int BufW    = 5;
	localparam int ErrW    = 2;
	localparam int RefW    = 8;

	localparam logic [RefW-1:0] RefMax = 8'd255;

	typedef enum logic [CmdW-1:0] {
		CMD_GET     = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN     = 2'd2,
		CMD_UNPIN   = 2'd3
	} cmd_t;

	typedef enum logic [ErrW-1:0] {
		ERR_OK         = 2'd0,
		ERR_NO_FREE    = 2'd1,
		ERR_STEAL_NONE = 2'd2
	} err_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_INIT_BUF,
		OP_INIT_HEAD,
		OP_ACCEPT,
		OP_REL,
		OP_MOD,
		OP_WALK_START,
		OP_WALK_LOAD,
		OP_WALK_STEP,
		OP_HIT,
		OP_MISS,
		OP_SCAN,
		OP_STEAL_SETUP,
		OP_STEAL_CNT,
		OP_UNL_RD,
		OP_UNL_WR,
		OP_INS_RD,
		OP_INS_WR1,
		OP_INS_WR2,
		OP_GRANT,
		OP_ERR1,
		OP_ERR2,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_INIT_BUF,
		S_INIT_HEAD,
		S_IDLE,
		S_REL,
		S_MOD,
		S_W_START,
		S_W_LOAD,
		S_W_CHK,
		S_HIT,
		S_MISS,
		S_SCAN,
		S_SCAN_END,
		S_STEAL_CHK,
		S_STEAL_CNT,
		S_UNL_RD,
		S_UNL_WR,
		S_INS_RD,
		S_INS_WR1,
		S_INS_WR2,
		S_GRANT,
		S_ERR1,
		S_ERR2,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PUR_LOOKUP,
		PUR_STEAL,
		PUR_OWN
	} purpose_t;

	typedef struct packed {
		op_t  op;
		logic walk_lru;
		logic walk_victim;
	} dp_cmd_t;

	typedef struct packed {
		logic init_last;
		logic is_get;
		logic rel_move;
		logic walk_end;
		logic walk_found;
		logic cnt_zero;
		logic scan_last;
		logic best_zero;
		logic moved_lt_want;
		logic out_free;
	} dp_status_t;

endpackage

### src/hlbc_if.sv
// Request and response channel interfaces of the buffer cache.
interface hlbc_req_if;
	import hlbc_pkg::*;
	logic                valid;
	logic                ready;
	logic [CmdW-1:0]     cmd;
	logic [DevW-1:0]     device;
	logic [BlkW-1:0]     block_number;
	logic [BufW-1:0]     buffer_id;
	modport source(output valid, cmd, device, block_number, buffer_id, input ready);
	modport sink(input valid, cmd, device, block_number, buffer_id, output ready);
endinterface

interface hlbc_rsp_if;
	import hlbc_pkg::*;
	logic                valid;
	logic                ready;
	logic [BufW-1:0]     granted_buffer;
	logic                was_hit;
	logic                needs_fill;
	logic [ErrW-1:0]     error_code;
	modport source(output valid, granted_buffer, was_hit, needs_fill, error_code, input ready);
	modport sink(input valid, granted_buffer, was_hit, needs_fill, error_code, output ready);
endinterface

### src/hlbc_ram.sv
// Generic single write port RAM with a registered read port.
module hlbc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### src/hlbc_dp.sv
// Datapath: buffer tags, counts, link memories, hash unit and result registers.
module hlbc_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hlbc_pkg::dp_cmd_t      cmd,
	output hlbc_pkg::dp_status_t   status,
	input  logic [hlbc_pkg::CmdW-1:0] in_cmd,
	input  logic [hlbc_pkg::DevW-1:0] in_device,
	input  logic [hlbc_pkg::BlkW-1:0] in_block_number,
	input  logic [hlbc_pkg::BufW-1:0] in_buffer_id,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [hlbc_pkg::BufW-1:0] out_granted_buffer,
	output logic                   out_was_hit,
	output logic                   out_needs_fill,
	output logic [hlbc_pkg::ErrW-1:0] out_error_code
);
	import hlbc_pkg::*;

	cmd_t              cmd_q;
	logic [DevW-1:0]   dev_q;
	logic [BlkW-1:0]   blk_q;
	logic              id_ok_q;
	logic [NodeW-1:0]  cur_q;
	logic [NodeW-1:0]  term_q;
	logic [NodeW-1:0]  nbr_q;
	logic [CntW-1:0]   steps_q;
	logic [BlkW-1:0]   mod_in_q;
	logic [BktW-1:0]   mod_rem_q;
	logic [BktW-1:0]   scan_q;
	logic [BktW-1:0]   victim_q;
	logic [CntW-1:0]   best_q;
	logic [CntW-1:0]   want_q;
	logic [CntW-1:0]   moved_q;
	logic [BufIdxW-1:0] init_q;
	logic [BktW-1:0]   init_r_q;
	logic [BufW-1:0]   res_granted_q;
	logic              res_hit_q;
	logic              res_fill_q;
	err_t              res_err_q;
	logic              out_valid_q;
	logic [BufW-1:0]   out_granted_q;
	logic              out_hit_q;
	logic              out_fill_q;
	logic [ErrW-1:0]   out_err_q;

	logic [DevW-1:0] tag_dev_q [NumBuffers];
	logic [BlkW-1:0] tag_blk_q [NumBuffers];
	logic [RefW-1:0] ref_q     [NumBuffers];
	logic            valid_q   [NumBuffers];
	logic [CntW-1:0] cnt_q     [NumBuckets];

	logic [BufIdxW-1:0] buf_idx;
	logic [RefW-1:0]    ref_rd;
	logic               valid_rd;
	logic [BktW-1:0]    cnt_idx;
	logic [CntW-1:0]    cnt_rd;
	logic [NodeW-1:0]   head_own;
	logic [NodeW-1:0]   head_victim;
	logic [NodeW-1:0]   init_node;
	logic [NodeW-1:0]   init_head;
	logic               tag_hit;
	logic               is_get;

	logic               nx_we, pv_we;
	logic [NodeW-1:0]   nx_wa, nx_wd, pv_wa, pv_wd, rd_addr;
	logic [NodeW-1:0]   nx_rd, pv_rd;

	// Remainder by 13: the nibbles weigh 1, 3, 9 and 1 since 16, 256 and 4096
	// reduce to those values; the sum is folded once more and brought into range.
	function automatic logic [BktW-1:0] rem_bucket(input logic [BlkW-1:0] x);
		logic [7:0] fold1;
		logic [5:0] fold2;
		fold1 = 8'(x[3:0]) + 8'({x[7:4], 1'b0}) + 8'(x[7:4])
			+ 8'({x[11:8], 3'b000}) + 8'(x[11:8]) + 8'(x[15:12]);
		fold2 = 6'(fold1[3:0]) + 6'({fold1[7:4], 1'b0}) + 6'(fold1[7:4]);
		if (fold2 >= 6'd52) begin
			fold2 = fold2 - 6'd52;
		end else if (fold2 >= 6'd39) begin
			fold2 = fold2 - 6'd39;
		end else if (fold2 >= 6'd26) begin
			fold2 = fold2 - 6'd26;
		end else if (fold2 >= 6'd13) begin
			fold2 = fold2 - 6'd13;
		end
		return fold2[BktW-1:0];
	endfunction

	hlbc_ram #(.Width(NodeW), .Depth(NodeCount)) u_next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(rd_addr), .rdata(nx_rd)
	);

	hlbc_ram #(.Width(NodeW), .Depth(NodeCount)) u_prev_ram (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(rd_addr), .rdata(pv_rd)
	);

	assign buf_idx     = cur_q[BufIdxW-1:0];
	assign ref_rd      = ref_q[buf_idx];
	assign valid_rd    = valid_q[buf_idx];
	assign cnt_idx     = (cmd.op == OP_SCAN) ? scan_q : mod_rem_q;
	assign cnt_rd      = cnt_q[cnt_idx];
	assign head_own    = NodeW'(NumBuffers) + NodeW'(mod_rem_q);
	assign head_victim = NodeW'(NumBuffers) + NodeW'(victim_q);
	assign init_node   = NodeW'(init_q);
	assign init_head   = NodeW'(NumBuffers) + NodeW'(init_r_q);
	assign tag_hit     = (tag_dev_q[buf_idx] == dev_q) && (tag_blk_q[buf_idx] == blk_q);
	assign is_get      = (cmd_q == CMD_GET);

	always_comb begin
		status.init_last     = (init_q == BufIdxW'(NumBuffers - 1));
		status.is_get        = is_get;
		status.rel_move      = (cmd_q == CMD_RELEASE) && id_ok_q && (ref_rd == RefW'(1));
		status.walk_end      = (cur_q == term_q) || (int'(cur_q) >= NumBuffers)
			|| (int'(steps_q) >= NumBuffers);
		status.walk_found    = cmd.walk_lru ? (ref_rd == '0) : tag_hit;
		status.cnt_zero      = (cnt_rd == '0);
		status.scan_last     = (scan_q == BktW'(NumBuckets - 1));
		status.best_zero     = (best_q == '0);
		status.moved_lt_want = (moved_q < want_q);
		status.out_free      = !out_valid_q || out_ready;
	end

	// Link memory ports. Buffers occupy the low nodes, bucket heads the high ones.
	always_comb begin
		nx_we   = 1'b0;
		nx_wa   = cur_q;
		nx_wd   = cur_q;
		pv_we   = 1'b0;
		pv_wa   = cur_q;
		pv_wd   = cur_q;
		rd_addr = cur_q;
		case (cmd.op)
			OP_INIT_BUF: begin
				nx_we = 1'b1;
				nx_wa = init_node;
				nx_wd = (int'(init_q) >= NumBuckets) ? init_node - NodeW'(NumBuckets) : init_head;
				pv_we = 1'b1;
				pv_wa = init_node;
				pv_wd = (int'(init_q) + NumBuckets < NumBuffers)
					? init_node + NodeW'(NumBuckets) : init_head;
			end
			OP_INIT_HEAD: begin
				pv_we = (int'(init_q) < NumBuckets);
				pv_wa = init_head;
				pv_wd = init_node;
				nx_we = (int'(init_q) + NumBuckets >= NumBuffers);
				nx_wa = init_head;
				nx_wd = init_node;
			end
			OP_WALK_START: rd_addr = cmd.walk_victim ? head_victim : head_own;
			OP_INS_RD:     rd_addr = head_own;
			OP_UNL_WR: begin
				nx_we = 1'b1;
				nx_wa = pv_rd;
				nx_wd = nx_rd;
				pv_we = 1'b1;
				pv_wa = nx_rd;
				pv_wd = pv_rd;
			end
			OP_INS_WR1: begin
				nx_we = 1'b1;
				nx_wd = is_get ? head_own : nx_rd;
				pv_we = 1'b1;
				pv_wd = is_get ? pv_rd : head_own;
			end
			OP_INS_WR2: begin
				nx_we = 1'b1;
				nx_wa = is_get ? nbr_q : head_own;
				pv_we = 1'b1;
				pv_wa = is_get ? head_own : nbr_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= '0;
			init_r_q    <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NumBuffers; i++) begin
				tag_dev_q[i] <= '0;
				tag_blk_q[i] <= '0;
				ref_q[i]     <= '0;
				valid_q[i]   <= 1'b0;
			end
			for (int i = 0; i < NumBuckets; i++) begin
				cnt_q[i] <= CntW'((NumBuffers - 1 - i) / NumBuckets + 1);
			end
		end else begin
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_INIT_HEAD: begin
					init_q   <= init_q + 1'b1;
					init_r_q <= (init_r_q == BktW'(NumBuckets - 1)) ? '0 : init_r_q + 1'b1;
				end
				OP_REL: begin
					if (id_ok_q) begin
						if (cmd_q == CMD_PIN) begin
							if (ref_rd < RefMax) ref_q[buf_idx] <= ref_rd + 1'b1;
						end else if (ref_rd != '0) begin
							ref_q[buf_idx] <= ref_rd - 1'b1;
						end
					end
				end
				OP_HIT: begin
					if (ref_rd == '0 && cnt_rd != '0) cnt_q[cnt_idx] <= cnt_rd - 1'b1;
					if (ref_rd < RefMax) ref_q[buf_idx] <= ref_rd + 1'b1;
					valid_q[buf_idx] <= 1'b1;
				end
				OP_STEAL_CNT: begin
					// The own bucket was empty and the victim held the best count.
					cnt_q[mod_rem_q] <= moved_q;
					cnt_q[victim_q]  <= best_q - moved_q;
				end
				OP_INS_WR2: begin
					if (!is_get && int'(cnt_rd) < NumBuffers) cnt_q[cnt_idx] <= cnt_rd + 1'b1;
				end
				OP_GRANT: begin
					if (cnt_rd != '0) cnt_q[cnt_idx] <= cnt_rd - 1'b1;
					tag_dev_q[buf_idx] <= dev_q;
					tag_blk_q[buf_idx] <= blk_q;
					ref_q[buf_idx]     <= RefW'(1);
					valid_q[buf_idx]   <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				cmd_q         <= cmd_t'(in_cmd);
				dev_q         <= in_device;
				blk_q         <= in_block_number;
				id_ok_q       <= (int'(in_buffer_id) < NumBuffers);
				cur_q         <= NodeW'(in_buffer_id);
				mod_in_q      <= in_block_number;
				mod_rem_q     <= '0;
				res_granted_q <= in_buffer_id;
				res_hit_q     <= 1'b0;
				res_fill_q    <= 1'b0;
				res_err_q     <= ERR_OK;
			end
			OP_REL:   mod_in_q  <= tag_blk_q[buf_idx];
			OP_MOD:   mod_rem_q <= rem_bucket(mod_in_q);
			OP_WALK_START: begin
				term_q  <= cmd.walk_victim ? head_victim : head_own;
				steps_q <= '0;
			end
			OP_WALK_LOAD: cur_q   <= cmd.walk_lru ? pv_rd : nx_rd;
			OP_WALK_STEP: steps_q <= steps_q + 1'b1;
			OP_HIT: begin
				res_granted_q <= cur_q[BufW-1:0];
				res_hit_q     <= 1'b1;
				res_fill_q    <= !valid_rd;
			end
			OP_MISS: begin
				scan_q   <= '0;
				best_q   <= '0;
				victim_q <= '0;
			end
			OP_SCAN: begin
				if (cnt_rd > best_q) begin
					best_q   <= cnt_rd;
					victim_q <= scan_q;
				end
				scan_q <= scan_q + 1'b1;
			end
			OP_STEAL_SETUP: begin
				want_q  <= best_q >> 1;
				moved_q <= '0;
			end
			OP_INS_WR1: nbr_q <= is_get ? pv_rd : nx_rd;
			OP_INS_WR2: begin
				if (is_get) moved_q <= moved_q + 1'b1;
			end
			OP_GRANT: begin
				res_granted_q <= cur_q[BufW-1:0];
				res_fill_q    <= 1'b1;
			end
			OP_ERR1: begin
				res_granted_q <= '0;
				res_err_q     <= ERR_NO_FREE;
			end
			OP_ERR2: begin
				res_granted_q <= '0;
				res_err_q     <= ERR_STEAL_NONE;
			end
			OP_OUT: begin
				out_granted_q <= res_granted_q;
				out_hit_q     <= res_hit_q;
				out_fill_q    <= res_fill_q;
				out_err_q     <= res_err_q;
			end
			default: ;
		endcase
	end

	assign out_valid          = out_valid_q;
	assign out_granted_buffer = out_granted_q;
	assign out_was_hit        = out_hit_q;
	assign out_needs_fill     = out_fill_q;
	assign out_error_code     = out_err_q;
endmodule

### src/hlbc_ctrl.sv
// Controller state machine that sequences every command through the datapath.
module hlbc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hlbc_pkg::dp_status_t status,
	input  logic                 in_valid,
	output logic                 in_ready,
	output hlbc_pkg::dp_cmd_t    cmd
);
	import hlbc_pkg::*;

	state_t   state_q, state_d;
	purpose_t purpose_q, purpose_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT_BUF;
			purpose_q <= PUR_LOOKUP;
		end else begin
			state_q   <= state_d;
			purpose_q <= purpose_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		purpose_d       = purpose_q;
		in_ready        = 1'b0;
		cmd.op          = OP_NONE;
		cmd.walk_lru    = (purpose_q != PUR_LOOKUP);
		cmd.walk_victim = (purpose_q == PUR_STEAL);
		case (state_q)
			S_INIT_BUF: begin
				cmd.op  = OP_INIT_BUF;
				state_d = S_INIT_HEAD;
			end
			S_INIT_HEAD: begin
				cmd.op  = OP_INIT_HEAD;
				state_d = status.init_last ? S_IDLE : S_INIT_BUF;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op    = OP_ACCEPT;
					purpose_d = PUR_LOOKUP;
					state_d   = S_MOD;
				end
			end
			S_MOD: begin
				// A get is hashed at once; a release only comes back here for a bucket move.
				if (!status.is_get && purpose_q == PUR_LOOKUP) begin
					state_d = S_REL;
				end else begin
					cmd.op = OP_MOD;
					if (status.is_get) begin
						purpose_d = PUR_LOOKUP;
						state_d   = S_W_START;
					end else begin
						state_d = S_UNL_RD;
					end
				end
			end
			S_REL: begin
				cmd.op = OP_REL;
				if (status.rel_move) begin
					purpose_d = PUR_OWN;
					state_d   = S_MOD;
				end else begin
					state_d = S_OUT;
				end
			end
			S_W_START: begin
				cmd.op  = OP_WALK_START;
				state_d = S_W_LOAD;
			end
			S_W_LOAD: begin
				cmd.op  = OP_WALK_LOAD;
				state_d = S_W_CHK;
			end
			S_W_CHK: begin
				if (status.walk_end) begin
					case (purpose_q)
						PUR_LOOKUP: state_d = S_MISS;
						PUR_STEAL:  state_d = S_STEAL_CNT;
						default:    state_d = S_ERR2;
					endcase
				end else if (status.walk_found) begin
					case (purpose_q)
						PUR_LOOKUP: state_d = S_HIT;
						PUR_STEAL:  state_d = S_UNL_RD;
						default:    state_d = S_GRANT;
					endcase
				end else begin
					cmd.op  = OP_WALK_STEP;
					state_d = S_W_LOAD;
				end
			end
			S_HIT: begin
				cmd.op  = OP_HIT;
				state_d = S_OUT;
			end
			S_MISS: begin
				cmd.op = OP_MISS;
				if (status.cnt_zero) begin
					state_d = S_SCAN;
				end else begin
					purpose_d = PUR_OWN;
					state_d   = S_W_START;
				end
			end
			S_SCAN: begin
				cmd.op = OP_SCAN;
				if (status.scan_last) state_d = S_SCAN_END;
			end
			S_SCAN_END: begin
				if (status.best_zero) begin
					state_d = S_ERR1;
				end else begin
					cmd.op  = OP_STEAL_SETUP;
					state_d = S_STEAL_CHK;
				end
			end
			S_STEAL_CHK: begin
				if (status.moved_lt_want) begin
					purpose_d = PUR_STEAL;
					state_d   = S_W_START;
				end else begin
					state_d = S_STEAL_CNT;
				end
			end
			S_STEAL_CNT: begin
				cmd.op    = OP_STEAL_CNT;
				purpose_d = PUR_OWN;
				state_d   = S_W_START;
			end
			S_UNL_RD: begin
				cmd.op  = OP_UNL_RD;
				state_d = S_UNL_WR;
			end
			S_UNL_WR: begin
				cmd.op  = OP_UNL_WR;
				state_d = S_INS_RD;
			end
			S_INS_RD: begin
				cmd.op  = OP_INS_RD;
				state_d = S_INS_WR1;
			end
			S_INS_WR1: begin
				cmd.op  = OP_INS_WR1;
				state_d = S_INS_WR2;
			end
			S_INS_WR2: begin
				cmd.op  = OP_INS_WR2;
				state_d = status.is_get ? S_STEAL_CHK : S_OUT;
			end
			S_GRANT: begin
				cmd.op  = OP_GRANT;
				state_d = S_OUT;
			end
			S_ERR1: begin
				cmd.op  = OP_ERR1;
				state_d = S_OUT;
			end
			S_ERR2: begin
				cmd.op  = OP_ERR2;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### src/hashed_lru_block_buffer_cache.sv
// Top level of the hashed LRU block buffer cache.
//
// Requests arrive on req (cmd, device, block_number, buffer_id) and each one
// produces exactly one response on rsp (granted_buffer, was_hit, needs_fill,
// error_code). A transfer happens on a rising edge with valid and ready high.
// The block works on one request at a time; req.ready is high only when idle,
// which is the cycle after a response has been loaded into the output register.
// A finished response sits in that register, so the next request can be
// taken while the receiver still holds rsp.ready low; a second response waits.
// A release that frees its buffer moves it in its bucket list. A get that hits
// walks its bucket list; a miss also walks the LRU search, and a get that
// must borrow buffers scans the bucket counts and then moves buffers one by
// one. The link memories, one read per cycle with registered data, set the
// walk rate. After reset the block fills the link memories with the initial
// bucket lists in one pass with req.ready low; after that all buffers are free.
module hashed_lru_block_buffer_cache (
	input logic        clk,
	input logic        arst_n,
	hlbc_req_if.sink   req,
	hlbc_rsp_if.source rsp
);
	import hlbc_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	hlbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (dp_status),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (dp_cmd)
	);

	hlbc_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (dp_cmd),
		.status             (dp_status),
		.in_cmd             (req.cmd),
		.in_device          (req.device),
		.in_block_number    (req.block_number),
		.in_buffer_id       (req.buffer_id),
		.out_ready          (rsp.ready),
		.out_valid          (rsp.valid),
		.out_granted_buffer (rsp.granted_buffer),
		.out_was_hit        (rsp.was_hit),
		.out_needs_fill     (rsp.needs_fill),
		.out_error_code     (rsp.error_code)
	);
endmodule
